/* src/blpg_pkg.sv */
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and constants of the line pixel generator
// coordinate widths, config register indexes, reset values, stage structs
// ----------------------------------------------------------------------------
package blpg_pkg;

  // endpoint coordinate width (supported range 8..32)
  localparam int COORD_BITS = 16;
  // frame dimension, column and row width
  localparam int DIM_W      = 16;
  // color width
  localparam int COLOR_W    = 24;
  // absolute delta along an axis fits in COORD_BITS unsigned bits
  localparam int DELTA_W    = COORD_BITS;
  // signed endpoint difference
  localparam int DIFF_W     = COORD_BITS + 1;
  // pixel countdown, holds delta + 1
  localparam int CNT_W      = COORD_BITS + 1;
  // decision variable, spans twice the largest delta either way
  localparam int ERR_W      = COORD_BITS + 3;
  // common width for the clip compare
  localparam int CMP_W      = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COLOR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR    = 2'd2;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 16'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 16'd480;
  localparam logic [COLOR_W-1:0] RST_PEN_COLOR    = 24'd0;

  // item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic               action;
    coord_t             start_x;
    coord_t             start_y;
    coord_t             end_x;
    coord_t             end_y;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [COLOR_W-1:0] pen_color;
  } cfg_t;

  // walk state prepared by a load
  typedef struct packed {
    logic                    major_is_x;
    logic                    minor_step_negative;
    coord_t                  cur_major;
    coord_t                  cur_minor;
    logic [DELTA_W-1:0]      major_delta;
    logic [DELTA_W-1:0]      minor_delta;
    logic signed [ERR_W-1:0] error_term;
    logic [CNT_W-1:0]        pixels_left;
  } line_setup_t;

  typedef struct packed {
    logic [DIM_W-1:0]   pixel_x;
    logic [DIM_W-1:0]   pixel_row;
    logic [COLOR_W-1:0] pixel_color;
    logic               write_enable;
    logic               last_pixel;
  } pixel_t;

endpackage

/* src/blpg_channels.sv */
// ----------------------------------------------------------------------------
// blpg channels: valid/ready interfaces for line items and pixels
// one interface per direction, each with source and sink modports
// ----------------------------------------------------------------------------
interface blpg_in_if;
  import blpg_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface blpg_out_if;
  import blpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIM_W-1:0]   pixel_x;
  logic [DIM_W-1:0]   pixel_row;
  logic [COLOR_W-1:0] pixel_color;
  logic               write_enable;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_row, pixel_color, write_enable, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_row, pixel_color, write_enable, last_pixel,
                  output ready);
endinterface

/* src/blpg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// blpg_cfg_regs: frame window and pen color registers
// written by index, unused indexes are dropped
// ----------------------------------------------------------------------------
module blpg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [blpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blpg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output blpg_pkg::cfg_t                   cfg
);
  import blpg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.pen_color    <= RST_PEN_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata[DIM_W-1:0];
        CFG_PEN_COLOR:    cfg_r.pen_color    <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/blpg_line_setup.sv */
// ----------------------------------------------------------------------------
// blpg_line_setup: endpoint to walk state conversion
// picks the major axis, orders endpoints, seeds the decision variable
// ----------------------------------------------------------------------------
module blpg_line_setup (
  input  blpg_pkg::in_item_t    item,
  output blpg_pkg::line_setup_t setup
);
  import blpg_pkg::*;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] adx;
  logic signed [DIFF_W-1:0] ady;
  logic signed [DIFF_W-1:0] d_major;
  logic signed [DIFF_W-1:0] d_minor;
  logic                     major_x;
  logic                     swap;
  logic                     minor_pos;
  logic                     minor_neg;
  logic [DELTA_W-1:0]       maj_delta;
  logic [DELTA_W-1:0]       min_delta;
  logic signed [ERR_W-1:0]  maj_ext;
  logic signed [ERR_W-1:0]  min_ext;

  always_comb begin
    dx  = DIFF_W'(item.end_x) - DIFF_W'(item.start_x);
    dy  = DIFF_W'(item.end_y) - DIFF_W'(item.start_y);
    adx = dx[DIFF_W-1] ? -dx : dx;
    ady = dy[DIFF_W-1] ? -dy : dy;

    // ties go to y
    major_x = adx > ady;

    d_major = major_x ? dx : dy;
    d_minor = major_x ? dy : dx;
    // endpoints are swapped when the major coordinate would fall
    swap    = d_major[DIFF_W-1];

    minor_neg = d_minor[DIFF_W-1];
    minor_pos = !d_minor[DIFF_W-1] && (d_minor != '0);

    maj_delta = major_x ? adx[DELTA_W-1:0] : ady[DELTA_W-1:0];
    min_delta = major_x ? ady[DELTA_W-1:0] : adx[DELTA_W-1:0];
    maj_ext   = ERR_W'(maj_delta);
    min_ext   = ERR_W'(min_delta);

    setup.major_is_x          = major_x;
    setup.minor_step_negative = swap ? minor_pos : minor_neg;
    setup.cur_major           = swap ? (major_x ? item.end_x : item.end_y)
                                     : (major_x ? item.start_x : item.start_y);
    setup.cur_minor           = swap ? (major_x ? item.end_y : item.end_x)
                                     : (major_x ? item.start_y : item.start_x);
    setup.major_delta         = maj_delta;
    setup.minor_delta         = min_delta;
    setup.error_term          = (min_ext <<< 1) - maj_ext;
    setup.pixels_left         = CNT_W'(maj_delta) + CNT_W'(1);
  end

endmodule

/* src/blpg_walker.sv */
// ----------------------------------------------------------------------------
// blpg_walker: line walk state and per-pixel clip and row flip
// one step of the decision variable update per advance
// ----------------------------------------------------------------------------
module blpg_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  advance,
  input  blpg_pkg::line_setup_t setup,
  input  blpg_pkg::cfg_t        cfg,
  output logic                  active,
  output blpg_pkg::pixel_t      pixel
);
  import blpg_pkg::*;

  logic                    active_r, active_nxt;
  line_setup_t             st_r, st_nxt;

  coord_t                  px;
  coord_t                  py;
  logic [CMP_W-1:0]        px_ext;
  logic [CMP_W-1:0]        py_ext;
  logic                    in_frame;
  logic                    last;
  logic signed [ERR_W-1:0] maj2;
  logic signed [ERR_W-1:0] min2;

  // current pixel, clip and row flip
  always_comb begin
    px       = st_r.major_is_x ? st_r.cur_major : st_r.cur_minor;
    py       = st_r.major_is_x ? st_r.cur_minor : st_r.cur_major;
    px_ext   = CMP_W'($unsigned(px));
    py_ext   = CMP_W'($unsigned(py));
    in_frame = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
               (px_ext < CMP_W'(cfg.frame_width)) &&
               (py_ext < CMP_W'(cfg.frame_height));
    last     = st_r.pixels_left <= CNT_W'(1);

    pixel.pixel_x      = in_frame ? px_ext[DIM_W-1:0] : '0;
    pixel.pixel_row    = in_frame ? (cfg.frame_height - DIM_W'(1) - py_ext[DIM_W-1:0]) : '0;
    pixel.pixel_color  = cfg.pen_color;
    pixel.write_enable = in_frame;
    pixel.last_pixel   = last;
  end

  // next walk state
  always_comb begin
    maj2       = ERR_W'(st_r.major_delta) <<< 1;
    min2       = ERR_W'(st_r.minor_delta) <<< 1;
    st_nxt     = st_r;
    active_nxt = active_r;
    if (load) begin
      st_nxt     = setup;
      active_nxt = 1'b1;
    end else if (advance) begin
      if (!st_r.error_term[ERR_W-1]) begin
        st_nxt.cur_minor  = st_r.minor_step_negative ? st_r.cur_minor - COORD_BITS'(1)
                                                     : st_r.cur_minor + COORD_BITS'(1);
        st_nxt.error_term = st_r.error_term - maj2 + min2;
      end else begin
        st_nxt.error_term = st_r.error_term + min2;
      end
      st_nxt.cur_major   = st_r.cur_major + COORD_BITS'(1);
      st_nxt.pixels_left = last ? '0 : st_r.pixels_left - CNT_W'(1);
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign active = active_r;

endmodule

/* src/bresenham_line_pixel_gen_unit.sv */
// ----------------------------------------------------------------------------
// bresenham_line_pixel_gen_unit: integer line rasterizer
// a step item is held in the input register stage, then its pixel in the result
// register; a stalled output holds both
// throughput: 1 item per cycle while out_if.ready holds, else the input stalls
// load items yield no pixel; steps while no line is active are dropped
// reset (synchronous, rst_n low): line idle, window 640 x 480, pen color 0
// ----------------------------------------------------------------------------
module bresenham_line_pixel_gen_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  blpg_in_if.sink                         in_if,
  blpg_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [blpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import blpg_pkg::*;

  // input register stage
  logic        in_valid_r, in_valid_nxt;
  in_item_t    in_item_r;
  in_item_t    in_item;

  // result register stage
  logic        out_valid_r, out_valid_nxt;
  pixel_t      out_pix_r;

  cfg_t        cfg;
  line_setup_t setup;
  pixel_t      pixel;
  logic        active;

  logic        out_free;   // result register can take a new pixel this cycle
  logic        stage_go;   // registered item is consumed this cycle
  logic        in_xfer;
  logic        do_load;
  logic        do_step;

  assign in_item.action  = in_if.action;
  assign in_item.start_x = in_if.start_x;
  assign in_item.start_y = in_if.start_y;
  assign in_item.end_x   = in_if.end_x;
  assign in_item.end_y   = in_if.end_y;

  // the result register frees up in the same cycle its pixel is taken
  assign out_free  = !out_valid_r || out_if.ready;
  assign stage_go  = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || stage_go;
  assign in_xfer   = in_if.valid && in_if.ready;

  // load replaces any line in progress; a step only counts on an active line
  assign do_load = stage_go && (in_item_r.action == ACT_LOAD);
  assign do_step = stage_go && (in_item_r.action == ACT_STEP) && active;

  blpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blpg_line_setup u_setup (
    .item  (in_item_r),
    .setup (setup)
  );

  blpg_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (do_load),
    .advance (do_step),
    .setup   (setup),
    .cfg     (cfg),
    .active  (active),
    .pixel   (pixel)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (stage_go) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (do_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_item;
    end
    if (do_step) begin
      out_pix_r <= pixel;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pixel_x      = out_pix_r.pixel_x;
  assign out_if.pixel_row    = out_pix_r.pixel_row;
  assign out_if.pixel_color  = out_pix_r.pixel_color;
  assign out_if.write_enable = out_pix_r.write_enable;
  assign out_if.last_pixel   = out_pix_r.last_pixel;

endmodule
